### sv/klt_pkg.sv
// ----------------------------------------------------------------------------
// klt_pkg: shared definitions for the kernel language tokenizer
// Scan modes, token kinds, error causes, character classes and keyword table.
// ----------------------------------------------------------------------------
package klt_pkg;

   // Default widths and queue depth
   localparam int KLT_POSITION_WIDTH = 16;
   localparam int KLT_LENGTH_WIDTH   = 8;
   localparam int KLT_QUEUE_DEPTH    = 4;
   // Most tokens one source byte can give rise to
   localparam int KLT_MAX_TOKENS     = 3;
   localparam int KLT_KEYWORDS       = 10;

   // Scanner modes (one byte of lookahead held as a mode)
   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_NUMBER,
      MODE_IDENT,
      MODE_COMMENT,
      MODE_SLASH,
      MODE_DOT,
      MODE_LESS,
      MODE_GREATER,
      MODE_EQUAL,
      MODE_BANG,
      MODE_HALT
   } mode_type;

   // Token kinds
   localparam logic [5:0] KIND_INT          = 6'd0;
   localparam logic [5:0] KIND_FLOAT        = 6'd1;
   localparam logic [5:0] KIND_IDENT        = 6'd2;
   localparam logic [5:0] KIND_KEYWORD_BASE = 6'd3;
   localparam logic [5:0] KIND_PLUS         = 6'd13;
   localparam logic [5:0] KIND_MINUS        = 6'd14;
   localparam logic [5:0] KIND_STAR         = 6'd15;
   localparam logic [5:0] KIND_SLASH        = 6'd16;
   localparam logic [5:0] KIND_PERCENT      = 6'd17;
   localparam logic [5:0] KIND_CARET        = 6'd18;
   localparam logic [5:0] KIND_TILDE        = 6'd19;
   localparam logic [5:0] KIND_LPAREN       = 6'd20;
   localparam logic [5:0] KIND_RPAREN       = 6'd21;
   localparam logic [5:0] KIND_LBRACE       = 6'd22;
   localparam logic [5:0] KIND_RBRACE       = 6'd23;
   localparam logic [5:0] KIND_LBRACKET     = 6'd24;
   localparam logic [5:0] KIND_RBRACKET     = 6'd25;
   localparam logic [5:0] KIND_COMMA        = 6'd26;
   localparam logic [5:0] KIND_SEMICOLON    = 6'd27;
   localparam logic [5:0] KIND_DOT          = 6'd28;
   localparam logic [5:0] KIND_AMPERSAND    = 6'd29;
   localparam logic [5:0] KIND_PIPE         = 6'd30;
   localparam logic [5:0] KIND_LT           = 6'd31;
   localparam logic [5:0] KIND_LE           = 6'd32;
   localparam logic [5:0] KIND_SHL          = 6'd33;
   localparam logic [5:0] KIND_GT           = 6'd34;
   localparam logic [5:0] KIND_GE           = 6'd35;
   localparam logic [5:0] KIND_SHR          = 6'd36;
   localparam logic [5:0] KIND_ASSIGN       = 6'd37;
   localparam logic [5:0] KIND_EQ           = 6'd38;
   localparam logic [5:0] KIND_NE           = 6'd39;
   localparam logic [5:0] KIND_EOF          = 6'd40;
   localparam logic [5:0] KIND_ERROR        = 6'd41;
   localparam logic [5:0] KIND_NONE         = 6'd63;

   // Error causes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_UNKNOWN = 2'd1;
   localparam logic [1:0] CAUSE_BANG    = 2'd2;

   // Characters with a meaning of their own
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_LESS       = 8'h3C;
   localparam logic [7:0] CHAR_GREATER    = 8'h3E;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3D;
   localparam logic [7:0] CHAR_BANG       = 8'h21;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   function automatic logic is_ident_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == CHAR_UNDERSCORE);
   endfunction

   // Single character operators; KIND_NONE when the byte is not one
   function automatic logic [5:0] single_op(input logic [7:0] c);
      logic [5:0] kind;
      kind = KIND_NONE;
      case (c)
         8'h2B:   kind = KIND_PLUS;
         8'h2D:   kind = KIND_MINUS;
         8'h2A:   kind = KIND_STAR;
         8'h25:   kind = KIND_PERCENT;
         8'h5E:   kind = KIND_CARET;
         8'h7E:   kind = KIND_TILDE;
         8'h28:   kind = KIND_LPAREN;
         8'h29:   kind = KIND_RPAREN;
         8'h7B:   kind = KIND_LBRACE;
         8'h7D:   kind = KIND_RBRACE;
         8'h5B:   kind = KIND_LBRACKET;
         8'h5D:   kind = KIND_RBRACKET;
         8'h2C:   kind = KIND_COMMA;
         8'h3B:   kind = KIND_SEMICOLON;
         8'h26:   kind = KIND_AMPERSAND;
         8'h7C:   kind = KIND_PIPE;
         default: kind = KIND_NONE;
      endcase
      return kind;
   endfunction

   // Keyword lengths
   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] len;
      case (k)
         0:       len = 4'd6;
         1:       len = 4'd3;
         2:       len = 4'd5;
         3:       len = 4'd3;
         4:       len = 4'd2;
         5:       len = 4'd4;
         6:       len = 4'd6;
         7:       len = 4'd9;
         8:       len = 4'd8;
         9:       len = 4'd8;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   // Keyword byte at a position; zero beyond the end of the keyword
   function automatic logic [7:0] kw_byte(input int k, input logic [3:0] pos);
      logic [79:0] text;
      logic [3:0]  len;
      logic [7:0]  b;
      case (k)
         0:       text = 80'("kernel");
         1:       text = 80'("int");
         2:       text = 80'("float");
         3:       text = 80'("for");
         4:       text = 80'("if");
         5:       text = 80'("else");
         6:       text = 80'("return");
         7:       text = 80'("threadIdx");
         8:       text = 80'("blockIdx");
         9:       text = 80'("blockDim");
         default: text = '0;
      endcase
      len = kw_len(k);
      if (pos >= len) begin
         b = 8'd0;
      end else begin
         b = text[8 * (int'(len) - 1 - int'(pos)) +: 8];
      end
      return b;
   endfunction

endpackage

### sv/klt_front.sv
// ----------------------------------------------------------------------------
// klt_front: byte scanner
// Accepts one source byte per transaction, runs the lookahead scanner and
// pushes the tokens the byte completes as one bundle into the token queue.
// ----------------------------------------------------------------------------
module klt_front #(
   parameter int POSITION_WIDTH = klt_pkg::KLT_POSITION_WIDTH,
   parameter int LENGTH_WIDTH   = klt_pkg::KLT_LENGTH_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   // source byte transactions
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_char_code,
   input  logic                         req_char_valid,
   input  logic                         req_end_of_source,
   // token bundle towards the queue
   output logic                         push_valid,
   input  logic                         push_ready,
   output logic [1:0]                   push_count,
   output logic [klt_pkg::KLT_MAX_TOKENS-1:0]
                [8+2*POSITION_WIDTH+LENGTH_WIDTH-1:0] push_tokens
);
   import klt_pkg::*;

   localparam int TOK_W = 8 + 2 * POSITION_WIDTH + LENGTH_WIDTH;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
   localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);
   localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = '1;
   localparam logic [LENGTH_WIDTH-1:0]   LEN_ONE = LENGTH_WIDTH'(1);
   localparam logic [LENGTH_WIDTH-1:0]   LEN_TWO = LENGTH_WIDTH'(2);

   // scanner state
   mode_type                    mode_ff, mode_in;
   logic [POSITION_WIDTH-1:0]   line_ff, line_in;
   logic [POSITION_WIDTH-1:0]   col_ff, col_in;
   logic [POSITION_WIDTH-1:0]   sline_ff, sline_in;
   logic [POSITION_WIDTH-1:0]   scol_ff, scol_in;
   logic [LENGTH_WIDTH-1:0]     count_ff, count_in;
   logic                        dot_ff, dot_in;
   logic [KLT_KEYWORDS-1:0]     cand_ff, cand_in;

   // per byte working values
   logic                        accept;
   logic                        go_idle;
   logic                        adv;
   logic [7:0]                  c;
   logic [5:0]                  op;
   logic [1:0]                  n_tok;
   logic [KLT_MAX_TOKENS-1:0][TOK_W-1:0] toks;

   function automatic logic [TOK_W-1:0] tok_pack(
      input logic [5:0]                kind,
      input logic [POSITION_WIDTH-1:0] line,
      input logic [POSITION_WIDTH-1:0] col,
      input logic [LENGTH_WIDTH-1:0]   len,
      input logic [1:0]                cause
   );
      return {kind, line, col, len, cause};
   endfunction

   // drop keywords whose byte at this position differs
   function automatic logic [KLT_KEYWORDS-1:0] narrow(
      input logic [KLT_KEYWORDS-1:0] cand,
      input logic [LENGTH_WIDTH-1:0] count,
      input logic [7:0]              ch
   );
      logic [KLT_KEYWORDS-1:0] res;
      res = cand;
      for (int k = 0; k < KLT_KEYWORDS; k++) begin
         if (!((count < LENGTH_WIDTH'(kw_len(k))) && (kw_byte(k, count[3:0]) == ch))) begin
            res[k] = 1'b0;
         end
      end
      return res;
   endfunction

   // first surviving keyword of full length, else identifier
   function automatic logic [5:0] ident_kind(
      input logic [KLT_KEYWORDS-1:0] cand,
      input logic [LENGTH_WIDTH-1:0] count
   );
      logic [5:0] kind;
      kind = KIND_IDENT;
      for (int k = KLT_KEYWORDS - 1; k >= 0; k--) begin
         if (cand[k] && (count == LENGTH_WIDTH'(kw_len(k)))) begin
            kind = KIND_KEYWORD_BASE + 6'(k);
         end
      end
      return kind;
   endfunction

   assign req_ready   = push_ready;
   assign accept      = req_valid && req_ready;
   assign c           = req_char_code;
   assign op          = single_op(c);
   assign push_valid  = req_valid && (n_tok != 2'd0);
   assign push_count  = n_tok;
   assign push_tokens = toks;

   // next state and tokens for the byte on the input
   always_comb begin
      mode_in  = mode_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      count_in = count_ff;
      dot_in   = dot_ff;
      cand_in  = cand_ff;
      go_idle  = 1'b0;
      adv      = 1'b0;
      n_tok    = 2'd0;
      toks     = '0;

      if (req_char_valid) begin
         // pending mode decides on the lookahead byte
         case (mode_ff)
            MODE_HALT: begin
            end
            MODE_COMMENT: begin
               if (c == CHAR_NEWLINE) go_idle = 1'b1;
               else adv = 1'b1;
            end
            MODE_NUMBER: begin
               if (is_digit(c) || (c == CHAR_DOT)) begin
                  if (c == CHAR_DOT) dot_in = 1'b1;
                  if (count_ff != LEN_MAX) count_in = count_ff + LEN_ONE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(dot_ff ? KIND_FLOAT : KIND_INT, sline_ff, scol_ff,
                                         count_ff, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_ident_char(c)) begin
                  cand_in = narrow(cand_ff, count_ff, c);
                  if (count_ff != LEN_MAX) count_in = count_ff + LEN_ONE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(ident_kind(cand_ff, count_ff), sline_ff, scol_ff,
                                         count_ff, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (c == CHAR_SLASH) begin
                  mode_in = MODE_COMMENT;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(KIND_SLASH, sline_ff, scol_ff, LEN_ONE, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_DOT: begin
               if (is_digit(c)) begin
                  mode_in = MODE_NUMBER;
                  dot_in = 1'b1;
                  if (count_ff != LEN_MAX) count_in = count_ff + LEN_ONE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(KIND_DOT, sline_ff, scol_ff, LEN_ONE, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_LESS: begin
               if ((c == CHAR_EQUAL) || (c == CHAR_LESS)) begin
                  toks[n_tok] = tok_pack((c == CHAR_EQUAL) ? KIND_LE : KIND_SHL,
                                         sline_ff, scol_ff, LEN_TWO, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  mode_in = MODE_IDLE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(KIND_LT, sline_ff, scol_ff, LEN_ONE, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_GREATER: begin
               if ((c == CHAR_EQUAL) || (c == CHAR_GREATER)) begin
                  toks[n_tok] = tok_pack((c == CHAR_EQUAL) ? KIND_GE : KIND_SHR,
                                         sline_ff, scol_ff, LEN_TWO, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  mode_in = MODE_IDLE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(KIND_GT, sline_ff, scol_ff, LEN_ONE, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_EQUAL: begin
               if (c == CHAR_EQUAL) begin
                  toks[n_tok] = tok_pack(KIND_EQ, sline_ff, scol_ff, LEN_TWO, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  mode_in = MODE_IDLE;
                  adv = 1'b1;
               end else begin
                  toks[n_tok] = tok_pack(KIND_ASSIGN, sline_ff, scol_ff, LEN_ONE, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  go_idle = 1'b1;
               end
            end
            MODE_BANG: begin
               if (c == CHAR_EQUAL) begin
                  toks[n_tok] = tok_pack(KIND_NE, sline_ff, scol_ff, LEN_TWO, CAUSE_NONE);
                  n_tok = n_tok + 2'd1;
                  mode_in = MODE_IDLE;
                  adv = 1'b1;
               end else begin
                  // lone '!': error, lookahead byte dropped
                  toks[n_tok] = tok_pack(KIND_ERROR, sline_ff, scol_ff, LEN_ONE, CAUSE_BANG);
                  n_tok = n_tok + 2'd1;
                  mode_in = MODE_HALT;
               end
            end
            default: begin
               go_idle = 1'b1;
            end
         endcase

         // byte seen between tokens
         if (go_idle) begin
            mode_in = MODE_IDLE;
            if (is_space(c)) begin
               adv = 1'b1;
            end else if (is_digit(c)) begin
               mode_in = MODE_NUMBER;
               dot_in  = 1'b0;
            end else if (is_alpha(c) || (c == CHAR_UNDERSCORE)) begin
               mode_in = MODE_IDENT;
               cand_in = narrow('1, '0, c);
            end else if (c == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (c == CHAR_DOT) begin
               mode_in = MODE_DOT;
            end else if (c == CHAR_LESS) begin
               mode_in = MODE_LESS;
            end else if (c == CHAR_GREATER) begin
               mode_in = MODE_GREATER;
            end else if (c == CHAR_EQUAL) begin
               mode_in = MODE_EQUAL;
            end else if (c == CHAR_BANG) begin
               mode_in = MODE_BANG;
            end else if (op == KIND_NONE) begin
               toks[n_tok] = tok_pack(KIND_ERROR, line_ff, col_ff, LEN_ONE, CAUSE_UNKNOWN);
               n_tok = n_tok + 2'd1;
               mode_in = MODE_HALT;
            end else begin
               toks[n_tok] = tok_pack(op, line_ff, col_ff, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
               adv = 1'b1;
            end
            // a pending mode starts a token here
            if ((mode_in != MODE_IDLE) && (mode_in != MODE_HALT)) begin
               sline_in = line_ff;
               scol_in  = col_ff;
               count_in = LEN_ONE;
               adv      = 1'b1;
            end
         end

         // position update, saturating
         if (adv) begin
            if (c == CHAR_NEWLINE) begin
               if (line_ff != POS_MAX) line_in = line_ff + POS_ONE;
               col_in = POS_ONE;
            end else if (col_ff != POS_MAX) begin
               col_in = col_ff + POS_ONE;
            end
         end
      end

      // end of source: flush pending token, then eof unless halted or on a lone '!', then back to reset
      if (req_end_of_source) begin
         case (mode_in)
            MODE_NUMBER: begin
               toks[n_tok] = tok_pack(dot_in ? KIND_FLOAT : KIND_INT, sline_in, scol_in,
                                      count_in, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_IDENT: begin
               toks[n_tok] = tok_pack(ident_kind(cand_in, count_in), sline_in, scol_in,
                                      count_in, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_SLASH: begin
               toks[n_tok] = tok_pack(KIND_SLASH, sline_in, scol_in, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_DOT: begin
               toks[n_tok] = tok_pack(KIND_DOT, sline_in, scol_in, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_LESS: begin
               toks[n_tok] = tok_pack(KIND_LT, sline_in, scol_in, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_GREATER: begin
               toks[n_tok] = tok_pack(KIND_GT, sline_in, scol_in, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_EQUAL: begin
               toks[n_tok] = tok_pack(KIND_ASSIGN, sline_in, scol_in, LEN_ONE, CAUSE_NONE);
               n_tok = n_tok + 2'd1;
            end
            MODE_BANG: begin
               toks[n_tok] = tok_pack(KIND_ERROR, sline_in, scol_in, LEN_ONE, CAUSE_BANG);
               n_tok = n_tok + 2'd1;
            end
            default: begin
            end
         endcase
         if ((mode_in != MODE_HALT) && (mode_in != MODE_BANG)) begin
            toks[n_tok] = tok_pack(KIND_EOF, line_in, col_in, '0, CAUSE_NONE);
            n_tok = n_tok + 2'd1;
         end
         mode_in  = MODE_IDLE;
         line_in  = POS_ONE;
         col_in   = POS_ONE;
         sline_in = POS_ONE;
         scol_in  = POS_ONE;
         count_in = '0;
         dot_in   = 1'b0;
         cand_in  = '1;
      end
   end

   // scanner state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= POS_ONE;
         col_ff   <= POS_ONE;
         sline_ff <= POS_ONE;
         scol_ff  <= POS_ONE;
         count_ff <= '0;
         dot_ff   <= 1'b0;
         cand_ff  <= '1;
      end else if (accept) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         sline_ff <= sline_in;
         scol_ff  <= scol_in;
         count_ff <= count_in;
         dot_ff   <= dot_in;
         cand_ff  <= cand_in;
      end
   end

endmodule

### sv/klt_back.sv
// ----------------------------------------------------------------------------
// klt_back: token queue and output serialiser
// Holds bundles of up to three tokens and hands them out one token per
// transaction, marking the last token of each bundle.
// ----------------------------------------------------------------------------
module klt_back #(
   parameter int POSITION_WIDTH = klt_pkg::KLT_POSITION_WIDTH,
   parameter int LENGTH_WIDTH   = klt_pkg::KLT_LENGTH_WIDTH,
   parameter int QUEUE_DEPTH    = klt_pkg::KLT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   // token bundle from the scanner
   input  logic                      push_valid,
   output logic                      push_ready,
   input  logic [1:0]                push_count,
   input  logic [klt_pkg::KLT_MAX_TOKENS-1:0]
                [8+2*POSITION_WIDTH+LENGTH_WIDTH-1:0] push_tokens,
   // token transactions
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [5:0]                rsp_token_kind,
   output logic [POSITION_WIDTH-1:0] rsp_start_line,
   output logic [POSITION_WIDTH-1:0] rsp_start_column,
   output logic [LENGTH_WIDTH-1:0]   rsp_token_length,
   output logic [1:0]                rsp_error_cause,
   output logic                      rsp_last_of_run
);
   import klt_pkg::*;

   localparam int TOK_W = 8 + 2 * POSITION_WIDTH + LENGTH_WIDTH;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W:0]   FILL_FULL = (PTR_W + 1)'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);

   // bundle storage
   logic [KLT_MAX_TOKENS-1:0][TOK_W-1:0] tok_mem [QUEUE_DEPTH];
   logic [1:0]                           cnt_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic [1:0]       idx_ff, idx_in;

   logic             push;
   logic             take;
   logic             pop;
   logic             last_tok;
   logic [TOK_W-1:0] head_tok;

   assign push_ready = (fill_ff != FILL_FULL);
   assign push       = push_valid && push_ready;
   assign rsp_valid  = (fill_ff != '0);
   assign take       = rsp_valid && rsp_ready;
   assign last_tok   = (2'(idx_ff + 2'd1) == cnt_mem[rd_ptr_ff]);
   assign pop        = take && last_tok;

   // head token onto the ports
   assign head_tok         = tok_mem[rd_ptr_ff][idx_ff];
   assign rsp_token_kind   = head_tok[TOK_W-1 -: 6];
   assign rsp_start_line   = head_tok[TOK_W-7 -: POSITION_WIDTH];
   assign rsp_start_column = head_tok[TOK_W-7-POSITION_WIDTH -: POSITION_WIDTH];
   assign rsp_token_length = head_tok[LENGTH_WIDTH+1:2];
   assign rsp_error_cause  = head_tok[1:0];
   assign rsp_last_of_run  = last_tok;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (take) begin
         idx_in = pop ? 2'd0 : idx_ff + 2'd1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) fill_in = fill_ff + (PTR_W + 1)'(1);
      else if (!push && pop) fill_in = fill_ff - (PTR_W + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         idx_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         idx_ff    <= idx_in;
      end
   end

   // bundle write
   always_ff @(posedge clock) begin
      if (push) begin
         tok_mem[wr_ptr_ff] <= push_tokens;
         cnt_mem[wr_ptr_ff] <= push_count;
      end
   end

endmodule

### sv/kernel_language_tokenizer.sv
// ----------------------------------------------------------------------------
// kernel_language_tokenizer: streaming tokenizer for a small kernel language
// Turns a byte stream into tokens with kind, start position and length.
//
//   Channel  Direction  Transaction
//   req_     in         one source byte, or a bare end marker
//   rsp_     out        one token; last_of_run closes the tokens of one byte
//
// One byte is accepted per cycle; the scanner decides on a single byte of
// lookahead in the cycle of acceptance. A byte yields up to three tokens, and
// the output hands out one token per cycle while rsp_ready is high, so bursts
// drain from the queue at that rate. With the queue empty, the first token of
// a byte is on rsp_ in the cycle after acceptance. Reset is synchronous; it
// returns to line 1, column 1. req_ready falls only while the queue is full.
// ----------------------------------------------------------------------------
module kernel_language_tokenizer #(
   parameter int POSITION_WIDTH = klt_pkg::KLT_POSITION_WIDTH,
   parameter int LENGTH_WIDTH   = klt_pkg::KLT_LENGTH_WIDTH,
   parameter int QUEUE_DEPTH    = klt_pkg::KLT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_char_code,
   input  logic                      req_char_valid,
   input  logic                      req_end_of_source,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [5:0]                rsp_token_kind,
   output logic [POSITION_WIDTH-1:0] rsp_start_line,
   output logic [POSITION_WIDTH-1:0] rsp_start_column,
   output logic [LENGTH_WIDTH-1:0]   rsp_token_length,
   output logic [1:0]                rsp_error_cause,
   output logic                      rsp_last_of_run
);
   import klt_pkg::*;

   localparam int TOK_W = 8 + 2 * POSITION_WIDTH + LENGTH_WIDTH;

   logic                                 push_valid;
   logic                                 push_ready;
   logic [1:0]                           push_count;
   logic [KLT_MAX_TOKENS-1:0][TOK_W-1:0] push_tokens;

   // scanner
   klt_front #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .LENGTH_WIDTH   (LENGTH_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_code     (req_char_code),
      .req_char_valid    (req_char_valid),
      .req_end_of_source (req_end_of_source),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_count        (push_count),
      .push_tokens       (push_tokens)
   );

   // token queue and output
   klt_back #(
      .POSITION_WIDTH (POSITION_WIDTH),
      .LENGTH_WIDTH   (LENGTH_WIDTH),
      .QUEUE_DEPTH    (QUEUE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_count       (push_count),
      .push_tokens      (push_tokens),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_line   (rsp_start_line),
      .rsp_start_column (rsp_start_column),
      .rsp_token_length (rsp_token_length),
      .rsp_error_cause  (rsp_error_cause),
      .rsp_last_of_run  (rsp_last_of_run)
   );

endmodule
